>>> src/d2cm_pkg.sv
package d2cm_pkg;

  // Field and register widths
  localparam int DEPTH_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int OFFSET_W     = 20;
  localparam int GAIN_W       = 21;
  localparam int CFG_DATA_W   = 21;
  localparam int CFG_ADDR_W   = 1;
  localparam int GAMMA_W      = 14;
  localparam int RAMP_W       = GAMMA_W - CHAN_W;

  // Default build
  localparam int LUT_ENTRIES_DEF = 2048;
  localparam int DEPTH_BITS_DEF  = 24;

  // Register reset values: 592.857 and 479.74 in Q8
  localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(151771);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(122814);

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DISP_OFFSET = 1'b0,
    REG_DISP_GAIN   = 1'b1
  } cfg_reg_t;

  // Color ramp codes, taken from the gamma word above the low byte
  localparam logic [RAMP_W-1:0] RAMP_WHITE_RED   = RAMP_W'(0);
  localparam logic [RAMP_W-1:0] RAMP_RED_YELLOW  = RAMP_W'(1);
  localparam logic [RAMP_W-1:0] RAMP_YELLOW_GRN  = RAMP_W'(2);
  localparam logic [RAMP_W-1:0] RAMP_GRN_CYAN    = RAMP_W'(3);
  localparam logic [RAMP_W-1:0] RAMP_CYAN_BLUE   = RAMP_W'(4);
  localparam logic [RAMP_W-1:0] RAMP_BLUE_BLACK  = RAMP_W'(5);

endpackage

>>> src/depth_to_color_map.sv
// Depth-to-color mapper. Each item carries one normalized depth sample (a fraction
// depth/2^DEPTH_BITS) and yields one RGB pixel in the depth-camera gamma coloring:
// disparity = offset + gain*depth (Q8 registers), truncated and clamped to
// [0, LUT_ENTRIES-1], cubed through the gamma curve, then mapped onto one of six
// color ramps (anything beyond the sixth ramp is black). The gamma curve is
// computed, not stored, so there is no load time after reset. Throughput is one
// item per clock unless the output stalls; five register stages (multiply, add and
// clamp, square, cube, gamma scale and ramp select). A stalled output backs up one
// stage at a time, so empty stages still take items. LUT_ENTRIES must be a power of
// two. The user must write configuration while idle; the block does not check it.
module depth_to_color_map #(
  parameter int LUT_ENTRIES = d2cm_pkg::LUT_ENTRIES_DEF,
  parameter int DEPTH_BITS  = d2cm_pkg::DEPTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [d2cm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [d2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // depth samples
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [d2cm_pkg::DEPTH_W-1:0]        in_tdata,   // [23:0] depth_sample
  // colored pixels
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [3*d2cm_pkg::CHAN_W-1:0]       out_tdata   // [7:0] red, [15:8] green,
                                                          // [23:16] blue
);
  import d2cm_pkg::*;

  localparam int STAGES = 5;
  localparam int LB     = $clog2(LUT_ENTRIES);
  localparam int DW     = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
  localparam int PROD_W = GAIN_W + DW + 1;
  localparam int ACC_W  = DEPTH_BITS + OFFSET_W + 2;
  localparam int Q_W    = OFFSET_W - 8 + 1;  // integer part of the disparity
  localparam int SQ_W   = 2 * LB;
  localparam int CUBE_W = 3 * LB;
  localparam int G9_W   = CUBE_W + 4;

  // Configuration registers
  logic [OFFSET_W-1:0] offset_r;
  logic [GAIN_W-1:0]   gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      gain_r   <= GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DISP_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        REG_DISP_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and load enables; a stage loads when empty or draining
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int k = STAGES-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: gain * depth
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic        [DW-1:0]     depth;

  assign depth    = in_tdata[DW-1:0];
  assign prod_nxt = PROD_W'($signed(gain_r)) * PROD_W'($signed({1'b0, depth}));

  always_ff @(posedge clk) begin
    if (en[0]) prod_r <= prod_nxt;
  end

  // Stage 2: add offset, truncate, clamp to the table range
  logic signed [ACC_W-1:0] acc;
  logic        [Q_W-1:0]   q_mag;
  logic        [LB-1:0]    idx_r, idx_nxt;

  always_comb begin
    acc   = $signed({2'b00, offset_r, {DEPTH_BITS{1'b0}}}) + ACC_W'(prod_r);
    q_mag = acc[DEPTH_BITS+8 +: Q_W];
    if (acc[ACC_W-1]) begin
      idx_nxt = '0;
    end else if (q_mag > Q_W'(LUT_ENTRIES - 1)) begin
      idx_nxt = {LB{1'b1}};
    end else begin
      idx_nxt = q_mag[LB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) idx_r <= idx_nxt;
  end

  // Stage 3: square
  logic [SQ_W-1:0] sq_r;
  logic [LB-1:0]   idx3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq_r   <= SQ_W'(idx_r) * SQ_W'(idx_r);
      idx3_r <= idx_r;
    end
  end

  // Stage 4: cube
  logic [CUBE_W-1:0] cube_r;

  always_ff @(posedge clk) begin
    if (en[3]) cube_r <= CUBE_W'(sq_r) * CUBE_W'(idx3_r);
  end

  // Stage 5: gamma = cube * 36 * 256 / 2^(3*LB), then ramp select
  logic [G9_W-1:0]    g9;
  logic [GAMMA_W-1:0] gamma;
  logic [CHAN_W-1:0]  lb;
  logic [RAMP_W-1:0]  ramp;
  logic [CHAN_W-1:0]  red_nxt, green_nxt, blue_nxt;
  logic [CHAN_W-1:0]  red_r, green_r, blue_r;

  always_comb begin
    g9    = {4'b0000, cube_r} + {1'b0, cube_r, 3'b000};
    gamma = g9[CUBE_W-10 +: GAMMA_W];
    lb    = gamma[CHAN_W-1:0];
    ramp  = gamma[GAMMA_W-1:CHAN_W];
    case (ramp)
      RAMP_WHITE_RED:  begin red_nxt = '1; green_nxt = ~lb; blue_nxt = ~lb; end
      RAMP_RED_YELLOW: begin red_nxt = '1; green_nxt = lb;  blue_nxt = '0;  end
      RAMP_YELLOW_GRN: begin red_nxt = ~lb; green_nxt = '1; blue_nxt = '0;  end
      RAMP_GRN_CYAN:   begin red_nxt = '0; green_nxt = '1;  blue_nxt = lb;  end
      RAMP_CYAN_BLUE:  begin red_nxt = '0; green_nxt = ~lb; blue_nxt = '1;  end
      RAMP_BLUE_BLACK: begin red_nxt = '0; green_nxt = '0;  blue_nxt = ~lb; end
      default:         begin red_nxt = '0; green_nxt = '0;  blue_nxt = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tdata = {blue_r, green_r, red_r};

  // Checks
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (v_r == '0))
    else $error("pipeline not empty after reset");

  a_hole_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(v_r) < STAGES |-> in_tready)
    else $error("input stalled with an empty stage");

  a_idx_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !en[1] |=> v_r[1] && $stable(idx_r))
    else $error("stalled index stage changed");

  a_cube_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && !en[3] |=> v_r[3] && $stable(cube_r))
    else $error("stalled cube stage changed");

endmodule

>>> verif/tb_depth_to_color_map.sv
module tb_depth_to_color_map;
  import d2cm_pkg::*;

  localparam int LATENCY     = 5;
  localparam int LUT_SIZE    = LUT_ENTRIES_DEF;
  localparam int DEPTH_BITS  = DEPTH_BITS_DEF;
  localparam int PHASE_ITEMS = 85;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_PHASE  = 4;
  localparam int HOLD_CYCLES = 60;
  localparam int SWEEP_Q8    = (LUT_SIZE - 1) * 256;
  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // one RGB pixel, laid out as on out_tdata (red in the low byte)
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // directed row: optional register load, then one depth item
  typedef struct packed {
    logic                  load;
    logic [CFG_DATA_W-1:0] offset_word;
    logic [CFG_DATA_W-1:0] gain_word;
    logic [DEPTH_W-1:0]    depth;
    logic                  typed;
    pixel_t                pixel;
  } vec_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = REG_DISP_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DEPTH_W-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [3*CHAN_W-1:0]   out_tdata;

  // register copies used by the color predictor
  logic [OFFSET_W-1:0]      shadow_offset = OFFSET_RST;
  logic signed [GAIN_W-1:0] shadow_gain   = GAIN_RST;

  pixel_t pending_pixels[$];
  int     items_sent   = 0;
  int     results_seen = 0;
  int     errors       = 0;
  int     in_gap_pct   = 0;
  int     out_gap_pct  = 0;
  int     phase_no     = -1;
  int     hold_left    = 0;
  bit     hold_done    = 1'b0;

  depth_to_color_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // disparity -> clamped index -> cubic gamma -> color ramp
  function automatic pixel_t pixel_for_depth(input logic [DEPTH_W-1:0] depth);
    longint              acc;
    longint unsigned     idx;
    longint unsigned     span;
    logic [GAMMA_W-1:0]  gamma;
    logic [RAMP_W-1:0]   ramp;
    logic [CHAN_W-1:0]   lb;
    pixel_t              pix;
    acc = (longint'(shadow_offset) << DEPTH_BITS)
        + longint'(shadow_gain) * longint'(depth);
    if (acc < 0)
      idx = 0;
    else
      idx = acc >> (DEPTH_BITS + 8);
    if (idx > LUT_SIZE - 1)
      idx = LUT_SIZE - 1;
    span = LUT_SIZE;
    span = span * span * span;
    gamma = GAMMA_W'((idx * idx * idx * (36 * 256)) / span);
    ramp = gamma[GAMMA_W-1:CHAN_W];
    lb = gamma[CHAN_W-1:0];
    pix = '0;
    case (ramp)
      RAMP_WHITE_RED: begin
        pix.red = CHAN_MAX; pix.green = CHAN_MAX - lb; pix.blue = CHAN_MAX - lb;
      end
      RAMP_RED_YELLOW: begin
        pix.red = CHAN_MAX; pix.green = lb;
      end
      RAMP_YELLOW_GRN: begin
        pix.red = CHAN_MAX - lb; pix.green = CHAN_MAX;
      end
      RAMP_GRN_CYAN: begin
        pix.green = CHAN_MAX; pix.blue = lb;
      end
      RAMP_CYAN_BLUE: begin
        pix.green = CHAN_MAX - lb; pix.blue = CHAN_MAX;
      end
      RAMP_BLUE_BLACK: begin
        pix.blue = CHAN_MAX - lb;
      end
      default: pix = '0;  // past the last ramp: black
    endcase
    return pix;
  endfunction

  function automatic vec_t vec(input logic load, input int offset_word, input int gain_word,
                               input int depth, input logic typed, input int pixel);
    vec_t v;
    v.load        = load;
    v.offset_word = CFG_DATA_W'(offset_word);
    v.gain_word   = CFG_DATA_W'(gain_word);
    v.depth       = DEPTH_W'(depth);
    v.typed       = typed;
    v.pixel       = pixel_t'(pixel[3*CHAN_W-1:0]);
    return v;
  endfunction

  // offer one depth item and record the pixel it must produce
  task automatic push_depth(input logic [DEPTH_W-1:0] depth, input logic typed,
                            input pixel_t pixel);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= depth;
    do @(posedge clk); while (!in_tready);
    pending_pixels = {pending_pixels, (typed ? pixel : pixel_for_depth(depth))};
    items_sent++;
  endtask

  // drain the pipe, then write both registers
  task automatic program_regs(input logic [CFG_DATA_W-1:0] offset_word,
                              input logic [CFG_DATA_W-1:0] gain_word);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen < items_sent) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_DISP_OFFSET;
    cfg_wdata <= offset_word;
    @(posedge clk);
    cfg_addr  <= REG_DISP_GAIN;
    cfg_wdata <= gain_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_offset = offset_word[OFFSET_W-1:0];
    shadow_gain   = gain_word;
  endtask

  // result side: random stalls, plus one long hold-off to back up the pipe
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (phase_no == HOLD_PHASE && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  // compare each accepted pixel with the oldest pending one
  always @(posedge clk) begin : pixel_check
    pixel_t got;
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  initial begin : stimulus
    vec_t                  vecs[$];
    logic [CFG_DATA_W-1:0] offset_word;
    logic [CFG_DATA_W-1:0] gain_word;
    logic [DEPTH_W-1:0]    depth;
    // after reset: disparity 592 -> first ramp
    vecs = {vecs, vec(0, 0, 0, 'h000000, 1, 'h2121FF)};
    vecs = {vecs, vec(0, 0, 0, 'hFFFFFF, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 'h800000, 0, 0)};
    // offset bit above the register width is dropped -> white
    vecs = {vecs, vec(1, 'h100000, 0, 'hABCDEF, 1, 'hFFFFFF)};
    // index clamps at the top of the curve, which lies past the last ramp
    vecs = {vecs, vec(1, 'h0FFFFF, 0, 'h000000, 1, 'h000000)};
    vecs = {vecs, vec(0, 0, 0, 'hFFFFFF, 1, 'h000000)};
    // negative disparity saturates to index zero
    vecs = {vecs, vec(1, 0, 'h100000, 'hFFFFFF, 1, 'hFFFFFF)};
    vecs = {vecs, vec(0, 0, 0, 'h000001, 1, 'hFFFFFF)};
    vecs = {vecs, vec(0, 0, 0, 'h000000, 1, 'hFFFFFF)};
    // sweep through every ramp and into black
    vecs = {vecs, vec(1, 0, SWEEP_Q8, 'h000000, 1, 'hFFFFFF)};
    vecs = {vecs, vec(0, 0, 0, 5819000, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 6901000, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 7721000, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 8393000, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 8975000, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 9483000, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 'hFFFFFF, 0, 0)};
    // largest offset against the most negative gain
    vecs = {vecs, vec(1, 'h0FFFFF, 'h100000, 'hFFFFFF, 1, 'hFFFFFF)};
    vecs = {vecs, vec(0, 0, 0, 'h000000, 1, 'h000000)};
    vecs = {vecs, vec(1, 'h0FFFFF, 'h0FFFFF, 'hFFFFFF, 1, 'h000000)};
    vecs = {vecs, vec(1, int'(OFFSET_RST), 'h1FFFFF, 'hFFFFFF, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 'h555555, 0, 0)};
    vecs = {vecs, vec(0, 0, 0, 'hAAAAAA, 0, 0)};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gap_pct = 33;
    out_gap_pct <= 83;

    foreach (vecs[k]) begin
      if (vecs[k].load)
        program_regs(vecs[k].offset_word, vecs[k].gain_word);
      push_depth(vecs[k].depth, vecs[k].typed, vecs[k].pixel);
    end

    // random phases, each with its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          offset_word = CFG_DATA_W'(OFFSET_RST);
          gain_word   = GAIN_RST;
        end
        1: begin
          offset_word = '0;
          gain_word   = CFG_DATA_W'(SWEEP_Q8);
        end
        3: begin
          offset_word = CFG_DATA_W'($urandom);
          gain_word   = CFG_DATA_W'($urandom);
        end
        5: begin
          offset_word = CFG_DATA_W'(SWEEP_Q8);
          gain_word   = CFG_DATA_W'(-SWEEP_Q8);
        end
        default: begin
          offset_word = CFG_DATA_W'($urandom_range(0, SWEEP_Q8));
          gain_word   = CFG_DATA_W'($urandom_range(0, 2 * SWEEP_Q8) - SWEEP_Q8);
        end
      endcase
      program_regs(offset_word, gain_word);
      in_gap_pct = (phase < 2) ? 33 : (phase < 4) ? 83 : 0;
      out_gap_pct <= (phase < 2) ? 83 : (phase < 4) ? 33 : 0;
      phase_no <= phase;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(15) == 0)
          depth = $urandom_range(1) ? '1 : '0;
        else
          depth = DEPTH_W'($urandom);
        push_depth(depth, 1'b0, '0);
      end
    end

    // wait for the last pixels, then keep waiting for strays
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen < items_sent) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
